FILE: hdl/assert_macros.svh
// Assertion macros used by the checker file of the timestamp ring search block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

FILE: hdl/trns_pkg.sv
// Shared constants, types and slot arithmetic for the timestamp ring search block.
`default_nettype none

package trns_pkg;

  localparam int MAX_SLOTS = 1024;
  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int CNT_W     = SLOT_W + 1;
  localparam int TIME_W    = 64;
  localparam int HANDLE_W  = 32;
  localparam int CMD_W     = 3;
  localparam int STAT_W    = 2;
  localparam int CAP_W     = 11;
  localparam int WORD_W    = TIME_W + HANDLE_W;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  localparam logic [CAP_W-1:0]    CAP_RESET    = 11'd1024;
  localparam logic [APB_AW-3:0]   IDX_CAPACITY = '0;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 3'd0,
    CMD_SEEK  = 3'd1,
    CMD_PREV  = 3'd2,
    CMD_NEXT  = 3'd3,
    CMD_QUERY = 3'd4
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_UNFILLED = 2'd2
  } stat_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_SK_RD,
    S_SK_CMP,
    S_RD_REP,
    S_RD_SEL,
    S_RD_PREV,
    S_RD_NEXT,
    S_RD_OLD,
    S_FIN,
    S_OUT
  } state_e;

  // Capacity register value limited to the usable range.
  function automatic logic [CNT_W-1:0] cap_clamp(input logic [CAP_W-1:0] raw);
    logic [CNT_W-1:0] c;
    c = CNT_W'(raw);
    if (c < CNT_W'(2)) begin
      c = CNT_W'(2);
    end else if (c > CNT_W'(MAX_SLOTS)) begin
      c = CNT_W'(MAX_SLOTS);
    end
    return c;
  endfunction

  function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] s,
                                                  input logic [CNT_W-1:0]  cap);
    logic [CNT_W-1:0] n;
    n = CNT_W'(s) + CNT_W'(1);
    if (n == cap) begin
      n = '0;
    end
    return n[SLOT_W-1:0];
  endfunction

  function automatic logic [SLOT_W-1:0] slot_prev(input logic [SLOT_W-1:0] s,
                                                  input logic [CNT_W-1:0]  cap);
    logic [CNT_W-1:0] p;
    p = (s == '0) ? (cap - CNT_W'(1)) : (CNT_W'(s) - CNT_W'(1));
    return p[SLOT_W-1:0];
  endfunction

  function automatic logic slot_filled(input logic [SLOT_W-1:0] s,
                                       input logic [CNT_W-1:0]  filled,
                                       input logic [CNT_W-1:0]  cap);
    return (CNT_W'(s) < cap) && ((filled >= cap) || (CNT_W'(s) < filled));
  endfunction

endpackage

`default_nettype wire

FILE: hdl/trns_if.sv
// Request and result channel interfaces of the timestamp ring search block.
`default_nettype none

interface trns_cmd_if import trns_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [TIME_W-1:0]   frame_time;
  logic [HANDLE_W-1:0] frame_handle;
  logic [TIME_W-1:0]   search_time;

  modport source (output valid, command, frame_time, frame_handle, search_time,
                  input ready);
  modport sink   (input valid, command, frame_time, frame_handle, search_time,
                  output ready);
endinterface

interface trns_rsp_if import trns_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STAT_W-1:0]   status;
  logic [HANDLE_W-1:0] found_handle;
  logic [TIME_W-1:0]   found_time;
  logic [SLOT_W-1:0]   slot;
  logic                has_previous;
  logic                has_next;
  logic                in_range;
  logic [TIME_W-1:0]   oldest_time;
  logic [TIME_W-1:0]   newest_time;
  logic [CNT_W-1:0]    fill_count;

  modport source (output valid, status, found_handle, found_time, slot, has_previous,
                  has_next, in_range, oldest_time, newest_time, fill_count,
                  input ready);
  modport sink   (input valid, status, found_handle, found_time, slot, has_previous,
                  has_next, in_range, oldest_time, newest_time, fill_count,
                  output ready);
endinterface

`default_nettype wire

FILE: hdl/timestamp_ring_nearest_search_core.sv
// Top level of the timestamp ring with nearest-time binary search.
//
//  Channel   Direction  Handshake                 Carries
//  cmd_i     in         valid/ready               command, frame_time, frame_handle,
//                                                 search_time
//  rsp_o     out        valid/ready               status, found slot, neighbor flags,
//                                                 time range, fill count
//  APB       in/out     psel/penable, pready = 1  capacity register at byte address 0
//
// A push, step or query request runs S_EXEC, then the readout states S_RD_REP, S_RD_SEL,
// S_RD_PREV, S_RD_NEXT, S_RD_OLD, S_FIN and S_OUT. A seek adds an S_SK_RD, S_SK_CMP pair
// per binary search probe, with at most floor(log2(fill_count)) + 1 probes (11 for 1024
// slots). Every probe and every slot readout goes through the single memory read port.
// Reset is asynchronous and active low; the slot memory itself is never cleared.
// A finished result waits in the output register while the next request is accepted;
// the sequencer stalls only at its final step when that register is still occupied.
`default_nettype none

module timestamp_ring_nearest_search_core import trns_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output      logic [APB_DW-1:0] prdata,
  output      logic              pready,
  trns_cmd_if.sink               cmd_i,
  trns_rsp_if.source             rsp_o
);

  // Control state.
  state_e              state_q, state_d;
  logic [CAP_W-1:0]    cap_raw_q, cap_raw_d;
  logic [CNT_W-1:0]    filled_q, filled_d;
  logic [SLOT_W-1:0]   newest_q, newest_d;
  logic [SLOT_W-1:0]   sel_q, sel_d;
  logic                sel_valid_q, sel_valid_d;
  logic [TIME_W-1:0]   latest_q, latest_d;
  logic                out_valid_q, out_valid_d;
  logic [CNT_W-1:0]    lo_q, lo_d;
  logic [CNT_W-1:0]    hip1_q, hip1_d;
  logic                have_q, have_d;
  logic                pend_q, pend_d;

  // Payload registers.
  logic [CMD_W-1:0]    cmd_q, cmd_d;
  logic [TIME_W-1:0]   ftime_q, ftime_d;
  logic [HANDLE_W-1:0] fhandle_q, fhandle_d;
  logic [TIME_W-1:0]   stime_q, stime_d;
  stat_e               status_q, status_d;
  logic                rep_valid_q, rep_valid_d;
  logic [SLOT_W-1:0]   rep_slot_q, rep_slot_d;
  logic [TIME_W-1:0]   best_q, best_d;
  logic [SLOT_W-1:0]   best_slot_q, best_slot_d;
  logic [SLOT_W-1:0]   probe_slot_q, probe_slot_d;
  logic [TIME_W-1:0]   dist_q, dist_d;
  logic [WORD_W-1:0]   rep_data_q, rep_data_d;
  logic [TIME_W-1:0]   sel_time_q, sel_time_d;
  logic [TIME_W-1:0]   prev_time_q, prev_time_d;
  logic [TIME_W-1:0]   next_time_q, next_time_d;
  logic [TIME_W-1:0]   old_time_q, old_time_d;

  // Output register.
  stat_e               o_status_q, o_status_d;
  logic [HANDLE_W-1:0] o_handle_q, o_handle_d;
  logic [TIME_W-1:0]   o_time_q, o_time_d;
  logic [SLOT_W-1:0]   o_slot_q, o_slot_d;
  logic                o_hp_q, o_hp_d;
  logic                o_hn_q, o_hn_d;
  logic                o_range_q, o_range_d;
  logic [TIME_W-1:0]   o_oldest_q, o_oldest_d;
  logic [TIME_W-1:0]   o_newest_q, o_newest_d;
  logic [CNT_W-1:0]    o_fill_q, o_fill_d;

  // Slot memory port.
  logic                ram_we;
  logic [SLOT_W-1:0]   ram_waddr;
  logic [WORD_W-1:0]   ram_wdata;
  logic [SLOT_W-1:0]   ram_raddr;
  logic [WORD_W-1:0]   ram_rdata;

  // Derived values.
  logic [CNT_W-1:0]    cap_eff;
  logic                ring_full;
  logic [SLOT_W-1:0]   oldest_slot;
  logic                sel_filled;
  logic [SLOT_W-1:0]   sel_prev;
  logic [SLOT_W-1:0]   sel_next;
  logic [SLOT_W-1:0]   push_slot;
  logic [SLOT_W-1:0]   step_tgt;
  logic [CNT_W-1:0]    mid;
  logic [CNT_W-1:0]    probe_sum;
  logic [CNT_W-1:0]    probe_wrap;
  logic [SLOT_W-1:0]   probe_slot;
  logic [TIME_W-1:0]   rd_time;
  logic [HANDLE_W-1:0] rd_handle;
  logic                rd_lt;
  logic [TIME_W-1:0]   rd_dist;
  logic                probe_wins;
  logic                cmd_fire;
  logic                cfg_we;
  logic                has_sel;
  logic                hp;
  logic                hn;

  trns_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_SLOTS)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // The capacity register is clamped into its usable range wherever the ring uses it.
  assign cap_eff     = cap_clamp(cap_raw_q);
  assign ring_full   = (filled_q >= cap_eff);
  // Until the ring wraps the oldest frame sits in slot 0; after that it is the slot
  // right behind the newest one.
  assign oldest_slot = ring_full ? slot_next(newest_q, cap_eff) : '0;
  assign sel_filled  = slot_filled(sel_q, filled_q, cap_eff);
  assign sel_prev    = slot_prev(sel_q, cap_eff);
  assign sel_next    = slot_next(sel_q, cap_eff);
  assign push_slot   = slot_next(newest_q, cap_eff);
  assign step_tgt    = (cmd_q == CMD_PREV) ? sel_prev : sel_next;

  // Binary search index math. The search runs on logical positions, oldest first,
  // over the half-open window [lo, hi+1). The logical midpoint maps onto a physical
  // slot with a single wrap correction, since oldest + mid stays below twice capacity.
  assign mid        = lo_q + ((hip1_q - CNT_W'(1) - lo_q) >> 1);
  assign probe_sum  = CNT_W'(oldest_slot) + mid;
  assign probe_wrap = (probe_sum >= cap_eff) ? (probe_sum - cap_eff) : probe_sum;
  assign probe_slot = probe_wrap[SLOT_W-1:0];

  // Shared compare/subtract unit: one probe result per pass.
  assign rd_time    = ram_rdata[WORD_W-1:HANDLE_W];
  assign rd_handle  = ram_rdata[HANDLE_W-1:0];
  assign rd_lt      = (rd_time < stime_q);
  assign rd_dist    = rd_lt ? (stime_q - rd_time) : (rd_time - stime_q);

  // A probe replaces the best candidate only on a strictly smaller distance, so on a
  // tie the earlier probe stays selected. The first probe is always taken.
  assign probe_wins = pend_q && (!have_q || (dist_q < best_q));

  assign cmd_fire   = cmd_i.valid && cmd_i.ready;
  assign cmd_i.ready = (state_q == S_IDLE);

  // Configuration port. Writes complete in the access phase; reads return the raw value.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[APB_AW-1:2] == IDX_CAPACITY);
  assign prdata = (paddr[APB_AW-1:2] == IDX_CAPACITY) ? APB_DW'(cap_raw_q) : '0;

  // Neighbor flags in timestamp order, from the times read back after the command.
  assign has_sel = sel_valid_q && sel_filled;
  assign hp = has_sel && !((sel_q == '0) && !ring_full)
           && slot_filled(sel_prev, filled_q, cap_eff) && (prev_time_q <= sel_time_q);
  assign hn = has_sel && slot_filled(sel_next, filled_q, cap_eff)
           && (next_time_q >= sel_time_q);

  always_comb begin
    state_d      = state_q;
    cap_raw_d    = cap_raw_q;
    filled_d     = filled_q;
    newest_d     = newest_q;
    sel_d        = sel_q;
    sel_valid_d  = sel_valid_q;
    latest_d     = latest_q;
    out_valid_d  = out_valid_q;
    lo_d         = lo_q;
    hip1_d       = hip1_q;
    have_d       = have_q;
    pend_d       = pend_q;
    cmd_d        = cmd_q;
    ftime_d      = ftime_q;
    fhandle_d    = fhandle_q;
    stime_d      = stime_q;
    status_d     = status_q;
    rep_valid_d  = rep_valid_q;
    rep_slot_d   = rep_slot_q;
    best_d       = best_q;
    best_slot_d  = best_slot_q;
    probe_slot_d = probe_slot_q;
    dist_d       = dist_q;
    rep_data_d   = rep_data_q;
    sel_time_d   = sel_time_q;
    prev_time_d  = prev_time_q;
    next_time_d  = next_time_q;
    old_time_d   = old_time_q;
    o_status_d   = o_status_q;
    o_handle_d   = o_handle_q;
    o_time_d     = o_time_q;
    o_slot_d     = o_slot_q;
    o_hp_d       = o_hp_q;
    o_hn_d       = o_hn_q;
    o_range_d    = o_range_q;
    o_oldest_d   = o_oldest_q;
    o_newest_d   = o_newest_q;
    o_fill_d     = o_fill_q;
    ram_we       = 1'b0;
    ram_waddr    = push_slot;
    ram_wdata    = {ftime_q, fhandle_q};
    ram_raddr    = sel_q;

    // The downstream side frees the output register on its own handshake.
    if (rsp_o.valid && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (cmd_fire) begin
          cmd_d     = cmd_i.command;
          ftime_d   = cmd_i.frame_time;
          fhandle_d = cmd_i.frame_handle;
          stime_d   = cmd_i.search_time;
          state_d   = S_EXEC;
        end
      end

      S_EXEC: begin
        status_d = ST_OK;
        state_d  = S_RD_REP;
        unique case (cmd_q)
          CMD_PUSH: begin
            // Oldest slot is overwritten once the ring is full.
            ram_we   = 1'b1;
            newest_d = push_slot;
            latest_d = ftime_q;
            if (!ring_full) begin
              filled_d = filled_q + CNT_W'(1);
            end
          end
          CMD_SEEK: begin
            if (filled_q == '0) begin
              status_d = ST_EMPTY;
            end else begin
              lo_d    = '0;
              hip1_d  = filled_q;
              have_d  = 1'b0;
              pend_d  = 1'b0;
              state_d = S_SK_RD;
            end
          end
          CMD_PREV, CMD_NEXT: begin
            if (!sel_valid_q || (filled_q == '0)) begin
              status_d = ST_EMPTY;
            end else if (!slot_filled(step_tgt, filled_q, cap_eff)) begin
              status_d = ST_UNFILLED;
            end else begin
              sel_d = step_tgt;
            end
          end
          default: begin
            // Query, and the unused codes that behave as a query.
            if (filled_q == '0) begin
              status_d = ST_EMPTY;
            end
          end
        endcase
      end

      S_SK_RD: begin
        // Retire the previous probe, then issue the next one or finish.
        pend_d = 1'b0;
        if (probe_wins) begin
          have_d      = 1'b1;
          best_d      = dist_q;
          best_slot_d = probe_slot_q;
        end
        if (lo_q < hip1_q) begin
          ram_raddr    = probe_slot;
          probe_slot_d = probe_slot;
          state_d      = S_SK_CMP;
        end else begin
          sel_d       = probe_wins ? probe_slot_q : best_slot_q;
          sel_valid_d = 1'b1;
          state_d     = S_RD_REP;
        end
      end

      S_SK_CMP: begin
        dist_d = rd_dist;
        pend_d = 1'b1;
        if (rd_lt) begin
          lo_d = mid + CNT_W'(1);
        end else begin
          hip1_d = mid;
        end
        state_d = S_SK_RD;
      end

      S_RD_REP: begin
        // A push reports the written slot; everything else reports the selection.
        ram_raddr   = (cmd_q == CMD_PUSH) ? newest_q : sel_q;
        rep_slot_d  = ram_raddr;
        rep_valid_d = (cmd_q == CMD_PUSH) || has_sel;
        state_d     = S_RD_SEL;
      end

      S_RD_SEL: begin
        ram_raddr  = sel_q;
        rep_data_d = {rd_time, rd_handle};
        state_d    = S_RD_PREV;
      end

      S_RD_PREV: begin
        ram_raddr  = sel_prev;
        sel_time_d = rd_time;
        state_d    = S_RD_NEXT;
      end

      S_RD_NEXT: begin
        ram_raddr   = sel_next;
        prev_time_d = rd_time;
        state_d     = S_RD_OLD;
      end

      S_RD_OLD: begin
        ram_raddr   = oldest_slot;
        next_time_d = rd_time;
        state_d     = S_FIN;
      end

      S_FIN: begin
        old_time_d = rd_time;
        state_d    = S_OUT;
      end

      S_OUT: begin
        if (!out_valid_q || rsp_o.ready) begin
          o_status_d  = status_q;
          o_handle_d  = rep_valid_q ? rep_data_q[HANDLE_W-1:0] : '0;
          o_time_d    = rep_valid_q ? rep_data_q[WORD_W-1:HANDLE_W] : '0;
          o_slot_d    = rep_valid_q ? rep_slot_q : '0;
          o_hp_d      = hp;
          o_hn_d      = hn;
          o_range_d   = (stime_q <= latest_q);
          o_oldest_d  = (filled_q != '0) ? old_time_q : '0;
          o_newest_d  = latest_q;
          o_fill_d    = filled_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Capacity write empties ring; user must write only while block is idle; unenforced.
    if (cfg_we) begin
      cap_raw_d   = pwdata[CAP_W-1:0];
      filled_d    = '0;
      newest_d    = SLOT_W'(cap_clamp(pwdata[CAP_W-1:0]) - CNT_W'(1));
      sel_d       = '0;
      sel_valid_d = 1'b0;
      latest_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cap_raw_q   <= CAP_RESET;
      filled_q    <= '0;
      newest_q    <= SLOT_W'(cap_clamp(CAP_RESET) - CNT_W'(1));
      sel_q       <= '0;
      sel_valid_q <= 1'b0;
      latest_q    <= '0;
      out_valid_q <= 1'b0;
      lo_q        <= '0;
      hip1_q      <= '0;
      have_q      <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      cap_raw_q   <= cap_raw_d;
      filled_q    <= filled_d;
      newest_q    <= newest_d;
      sel_q       <= sel_d;
      sel_valid_q <= sel_valid_d;
      latest_q    <= latest_d;
      out_valid_q <= out_valid_d;
      lo_q        <= lo_d;
      hip1_q      <= hip1_d;
      have_q      <= have_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    ftime_q      <= ftime_d;
    fhandle_q    <= fhandle_d;
    stime_q      <= stime_d;
    status_q     <= status_d;
    rep_valid_q  <= rep_valid_d;
    rep_slot_q   <= rep_slot_d;
    best_q       <= best_d;
    best_slot_q  <= best_slot_d;
    probe_slot_q <= probe_slot_d;
    dist_q       <= dist_d;
    rep_data_q   <= rep_data_d;
    sel_time_q   <= sel_time_d;
    prev_time_q  <= prev_time_d;
    next_time_q  <= next_time_d;
    old_time_q   <= old_time_d;
    o_status_q   <= o_status_d;
    o_handle_q   <= o_handle_d;
    o_time_q     <= o_time_d;
    o_slot_q     <= o_slot_d;
    o_hp_q       <= o_hp_d;
    o_hn_q       <= o_hn_d;
    o_range_q    <= o_range_d;
    o_oldest_q   <= o_oldest_d;
    o_newest_q   <= o_newest_d;
    o_fill_q     <= o_fill_d;
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = o_status_q;
  assign rsp_o.found_handle = o_handle_q;
  assign rsp_o.found_time   = o_time_q;
  assign rsp_o.slot         = o_slot_q;
  assign rsp_o.has_previous = o_hp_q;
  assign rsp_o.has_next     = o_hn_q;
  assign rsp_o.in_range     = o_range_q;
  assign rsp_o.oldest_time  = o_oldest_q;
  assign rsp_o.newest_time  = o_newest_q;
  assign rsp_o.fill_count   = o_fill_q;

endmodule

`default_nettype wire

FILE: hdl/trns_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module trns_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

FILE: hdl/trns_checker.sv
// Port-level assertions for the timestamp ring search block, bound to its top level.
`default_nettype none
`include "assert_macros.svh"

module trns_checker import trns_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              cmd_valid,
  input wire logic              cmd_ready,
  input wire logic              rsp_valid,
  input wire logic              rsp_ready,
  input wire logic [STAT_W-1:0] rsp_status,
  input wire logic [CNT_W-1:0]  rsp_fill_count,
  input wire logic              rsp_has_previous,
  input wire logic              rsp_has_next
);

  // A result that is not taken stays offered.
  `ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid && !rsp_ready, rsp_valid)

  // The block works on one request at a time, so it is busy right after an acceptance.
  `ASSERT_NEXT(a_busy_after_req, clk_i, rst_ni, cmd_valid && cmd_ready, !cmd_ready)

  // Only defined status codes appear.
  `ASSERT_IMPL(a_status_legal, clk_i, rst_ni, rsp_valid, (rsp_status == ST_OK) || (rsp_status == ST_EMPTY) || (rsp_status == ST_UNFILLED))

  // An empty ring always reports the empty status and no neighbors.
  `ASSERT_IMPL(a_empty_ring, clk_i, rst_ni, rsp_valid && (rsp_fill_count == '0), (rsp_status == ST_EMPTY) && !rsp_has_previous && !rsp_has_next)

  // The fill count never passes the number of slots.
  `ASSERT_IMPL(a_fill_bound, clk_i, rst_ni, rsp_valid, rsp_fill_count <= CNT_W'(MAX_SLOTS))

endmodule

bind timestamp_ring_nearest_search_core trns_checker u_trns_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .cmd_valid        (cmd_i.valid),
  .cmd_ready        (cmd_i.ready),
  .rsp_valid        (rsp_o.valid),
  .rsp_ready        (rsp_o.ready),
  .rsp_status       (rsp_o.status),
  .rsp_fill_count   (rsp_o.fill_count),
  .rsp_has_previous (rsp_o.has_previous),
  .rsp_has_next     (rsp_o.has_next)
);

`default_nettype wire

FILE: dv/tb_timestamp_ring_nearest_search_core.sv
// Self-checking testbench for the timestamp ring with nearest-time binary search.
module tb_timestamp_ring_nearest_search_core;
  import trns_pkg::*;

  // Run control. The slowest request is a seek over a full ring, and the settle pause
  // is meant to cover anything still in flight.
  localparam int RUN_LIMIT     = 1_000_000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PARK_CYCLES   = 300;

  // Command codes past CMD_QUERY. The block treats them as a query.
  localparam logic [CMD_W-1:0] CMD_SPARE_5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  localparam logic [APB_AW-1:0]   CAP_ADDR   = {IDX_CAPACITY, 2'b00};
  localparam logic [TIME_W-1:0]   TIME_MAX   = '1;
  localparam logic [HANDLE_W-1:0] HANDLE_MAX = '1;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [TIME_W-1:0]   frame_time;
    logic [HANDLE_W-1:0] frame_handle;
    logic [TIME_W-1:0]   search_time;
  } ring_req_t;

  typedef struct packed {
    logic [STAT_W-1:0]   status;
    logic [HANDLE_W-1:0] found_handle;
    logic [TIME_W-1:0]   found_time;
    logic [SLOT_W-1:0]   slot;
    logic                has_previous;
    logic                has_next;
    logic                in_range;
    logic [TIME_W-1:0]   oldest_time;
    logic [TIME_W-1:0]   newest_time;
    logic [CNT_W-1:0]    fill_count;
  } ring_rsp_t;

  // One line of the directed plan: either a capacity write or a request. A request
  // row may carry a hand-written result; otherwise the ring model supplies it.
  typedef struct {
    bit                is_cfg;
    logic [CAP_W-1:0]  cap_raw;
    ring_req_t         req;
    bit                typed;
    ring_rsp_t         want;
  } plan_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  trns_cmd_if cmd_bus ();
  trns_rsp_if rsp_bus ();

  timestamp_ring_nearest_search_core i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cmd_i   (cmd_bus),
    .rsp_o   (rsp_bus)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Ring model. It mirrors the slot stores, fill level, write pointer and the
  // selection cursor, and is advanced once per accepted request.
  // ---------------------------------------------------------------------------
  logic [TIME_W-1:0]   slot_time   [MAX_SLOTS];
  logic [HANDLE_W-1:0] slot_handle [MAX_SLOTS];
  int                  ring_cap       = MAX_SLOTS;
  int                  ring_fill      = 0;
  int                  head_slot      = MAX_SLOTS - 1;
  int                  cursor_slot    = 0;
  bit                  cursor_valid   = 1'b0;
  logic [TIME_W-1:0]   last_push_time = '0;

  ring_rsp_t ring_expect [$];
  int        mismatches = 0;
  int        burst_left = 0;
  int        park_asked = 0;
  plan_row_t plan [$];

  function automatic bit occupied(input int s);
    return (s < ring_cap) && ((ring_fill >= ring_cap) || (s < ring_fill));
  endfunction

  // The oldest frame sits in slot 0 until the ring wraps, then just past the head.
  function automatic int tail_slot();
    return (ring_fill < ring_cap) ? 0 : (head_slot + 1) % ring_cap;
  endfunction

  function automatic int ring_back(input int s);
    return (s == 0) ? ring_cap - 1 : s - 1;
  endfunction

  function automatic int ring_fwd(input int s);
    return (s + 1) % ring_cap;
  endfunction

  // Applies one request to the model and returns the result the block must give.
  function automatic ring_rsp_t ring_apply(input ring_req_t r);
    ring_rsp_t         o;
    bit                rep_ok;
    bit                moved;
    bit                have;
    int                rep;
    int                base;
    int                lo;
    int                hi;
    int                mid;
    int                phys;
    int                near_slot;
    int                tgt;
    logic [TIME_W-1:0] t;
    logic [TIME_W-1:0] d;
    logic [TIME_W-1:0] best;
    logic [TIME_W-1:0] ts;

    o      = '0;
    rep_ok = 1'b0;
    moved  = 1'b0;
    rep    = 0;
    case (r.command)
      CMD_PUSH: begin
        head_slot = (head_slot + 1) % ring_cap;
        slot_time[head_slot]   = r.frame_time;
        slot_handle[head_slot] = r.frame_handle;
        if (ring_fill < ring_cap) begin
          ring_fill++;
        end
        last_push_time = r.frame_time;
        rep_ok = 1'b1;
        rep    = head_slot;
        moved  = 1'b1;
      end
      CMD_SEEK: begin
        if (ring_fill == 0) begin
          o.status = ST_EMPTY;
        end else begin
          // Binary search in age order; only a strictly closer probe replaces
          // the candidate, so on a tie the earlier probe is kept.
          base      = tail_slot();
          lo        = 0;
          hi        = ring_fill - 1;
          have      = 1'b0;
          best      = '0;
          near_slot = 0;
          while (lo <= hi) begin
            mid  = lo + (hi - lo) / 2;
            phys = (base + mid) % ring_cap;
            t    = slot_time[phys];
            d    = (t >= r.search_time) ? t - r.search_time : r.search_time - t;
            if (!have || d < best) begin
              have      = 1'b1;
              best      = d;
              near_slot = phys;
            end
            if (t < r.search_time) begin
              lo = mid + 1;
            end else begin
              hi = mid - 1;
            end
          end
          cursor_slot  = near_slot;
          cursor_valid = 1'b1;
          rep_ok       = 1'b1;
          rep          = near_slot;
          moved        = 1'b1;
        end
      end
      CMD_PREV, CMD_NEXT: begin
        if (!cursor_valid || ring_fill == 0) begin
          o.status = ST_EMPTY;
        end else begin
          tgt = (r.command == CMD_PREV) ? ring_back(cursor_slot) : ring_fwd(cursor_slot);
          if (!occupied(tgt)) begin
            o.status = ST_UNFILLED;
          end else begin
            cursor_slot = tgt;
            rep_ok      = 1'b1;
            rep         = tgt;
            moved       = 1'b1;
          end
        end
      end
      default: begin
        if (ring_fill == 0) begin
          o.status = ST_EMPTY;
        end
      end
    endcase

    if (!moved && cursor_valid && occupied(cursor_slot)) begin
      rep_ok = 1'b1;
      rep    = cursor_slot;
    end
    if (rep_ok) begin
      o.found_handle = slot_handle[rep];
      o.found_time   = slot_time[rep];
      o.slot         = SLOT_W'(rep);
    end

    // Neighbor flags follow the selection, whatever the request reported.
    if (cursor_valid && occupied(cursor_slot)) begin
      ts = slot_time[cursor_slot];
      if (!(cursor_slot == 0 && ring_fill < ring_cap)) begin
        tgt = ring_back(cursor_slot);
        o.has_previous = occupied(tgt) && (slot_time[tgt] <= ts);
      end
      tgt = ring_fwd(cursor_slot);
      o.has_next = occupied(tgt) && (slot_time[tgt] >= ts);
    end

    o.in_range    = (r.search_time <= last_push_time);
    o.oldest_time = (ring_fill != 0) ? slot_time[tail_slot()] : '0;
    o.newest_time = last_push_time;
    o.fill_count  = CNT_W'(ring_fill);
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers. All block inputs change on the falling edge; handshakes are
  // sampled on the rising edge.
  // ---------------------------------------------------------------------------

  // Offers one request. The sender runs in bursts: when a burst is used up it
  // may drop valid for a random gap before the next one starts.
  task automatic send_request(input ring_req_t r, input bit typed, input ring_rsp_t lit);
    ring_rsp_t want;
    int        gap;

    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        cmd_bus.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    cmd_bus.valid        <= 1'b1;
    cmd_bus.command      <= r.command;
    cmd_bus.frame_time   <= r.frame_time;
    cmd_bus.frame_handle <= r.frame_handle;
    cmd_bus.search_time  <= r.search_time;
    @(posedge clk_i);
    while (cmd_bus.ready !== 1'b1) begin
      @(posedge clk_i);
    end
    // Accepted at this edge: the model moves on and its result joins the queue.
    // A row with a hand-written result still runs the model to keep its state.
    want = ring_apply(r);
    if (typed) begin
      want = lit;
    end
    ring_expect.insert(ring_expect.size(), want);
    @(negedge clk_i);
  endtask

  // Drops valid and waits until every request has been answered, then lets the
  // sequencer drain before anything touches the configuration.
  task automatic wait_idle();
    cmd_bus.valid <= 1'b0;
    burst_left = 0;
    while (ring_expect.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Two-phase register write. Writing the capacity empties the ring, so the
  // model is emptied at the same edge.
  task automatic write_capacity(input logic [CAP_W-1:0] cap_raw);
    int v;

    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAP_ADDR;
    pwdata  <= {(APB_DW-CAP_W)'($urandom), cap_raw};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) begin
      @(posedge clk_i);
    end
    v = cap_raw;
    if (v < 2) begin
      v = 2;
    end else if (v > MAX_SLOTS) begin
      v = MAX_SLOTS;
    end
    ring_cap       = v;
    ring_fill      = 0;
    head_slot      = ring_cap - 1;
    cursor_slot    = 0;
    cursor_valid   = 1'b0;
    last_push_time = '0;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Directed plan.
  // ---------------------------------------------------------------------------
  function automatic ring_rsp_t rsp_lit(input stat_e st, input logic [HANDLE_W-1:0] fh,
                                        input logic [TIME_W-1:0] ft,
                                        input logic [SLOT_W-1:0] sl, input logic hp,
                                        input logic hn, input logic inr,
                                        input logic [TIME_W-1:0] old_t,
                                        input logic [TIME_W-1:0] new_t,
                                        input logic [CNT_W-1:0] cnt);
    ring_rsp_t o;
    o = '{st, fh, ft, sl, hp, hn, inr, old_t, new_t, cnt};
    return o;
  endfunction

  task automatic plan_req(input logic [CMD_W-1:0] c, input logic [TIME_W-1:0] ft,
                          input logic [HANDLE_W-1:0] fh, input logic [TIME_W-1:0] st);
    plan_row_t p;
    p = '{1'b0, '0, '{c, ft, fh, st}, 1'b0, '0};
    plan.insert(plan.size(), p);
  endtask

  task automatic plan_lit(input logic [CMD_W-1:0] c, input logic [TIME_W-1:0] ft,
                          input logic [HANDLE_W-1:0] fh, input logic [TIME_W-1:0] st,
                          input ring_rsp_t want);
    plan_row_t p;
    p = '{1'b0, '0, '{c, ft, fh, st}, 1'b1, want};
    plan.insert(plan.size(), p);
  endtask

  task automatic plan_cfg(input logic [CAP_W-1:0] cap_raw);
    plan_row_t p;
    p = '{1'b1, cap_raw, '0, 1'b0, '0};
    plan.insert(plan.size(), p);
  endtask

  task automatic build_plan();
    // Fresh ring at the reset capacity: each command issued here fails on the empty ring.
    plan_lit(CMD_QUERY, 64'h0123, 32'h1, '0,
             rsp_lit(ST_EMPTY, '0, '0, '0, 0, 0, 1, '0, '0, '0));
    plan_lit(CMD_PREV, '0, '0, TIME_MAX,
             rsp_lit(ST_EMPTY, '0, '0, '0, 0, 0, 0, '0, '0, '0));
    plan_lit(CMD_NEXT, TIME_MAX, HANDLE_MAX, 64'd1,
             rsp_lit(ST_EMPTY, '0, '0, '0, 0, 0, 0, '0, '0, '0));
    plan_lit(CMD_SEEK, '0, '0, '0,
             rsp_lit(ST_EMPTY, '0, '0, '0, 0, 0, 1, '0, '0, '0));
    // First pushes land in slots 0 and 1 with extreme times and handles.
    plan_lit(CMD_PUSH, TIME_MAX, HANDLE_MAX, TIME_MAX,
             rsp_lit(ST_OK, HANDLE_MAX, TIME_MAX, 10'd0, 0, 0, 1, TIME_MAX, TIME_MAX, 11'd1));
    plan_lit(CMD_PUSH, '0, '0, 64'd1,
             rsp_lit(ST_OK, '0, '0, 10'd1, 0, 0, 0, TIME_MAX, '0, 11'd2));
    // Steps before any seek, then walks off both ends of a partly filled ring.
    plan_req(CMD_NEXT, 64'h55, 32'h55, 64'h5);
    plan_req(CMD_SEEK, '0, '0, '0);
    plan_req(CMD_NEXT, '0, '0, 64'h10);
    plan_req(CMD_NEXT, '0, '0, 64'h10);
    plan_req(CMD_PREV, '0, '0, 64'h10);
    plan_req(CMD_PREV, '0, '0, 64'h10);
    plan_req(CMD_SPARE_7, 64'hAAAA_5555_AAAA_5555, 32'h5555_AAAA, 64'h8000_0000_0000_0000);
    // A value below the legal range clamps to two slots; the third push wraps.
    plan_cfg(11'd1);
    plan_req(CMD_PUSH, 64'd10, 32'hA0, 64'd0);
    plan_req(CMD_PUSH, 64'd20, 32'hA1, 64'd20);
    plan_req(CMD_PUSH, 64'd30, 32'hA2, 64'd31);
    // Equal distance to both slots: the first probe must win.
    plan_req(CMD_SEEK, '0, '0, 64'd25);
    plan_req(CMD_NEXT, '0, '0, 64'd25);
    plan_req(CMD_NEXT, '0, '0, 64'd25);
    plan_req(CMD_PREV, '0, '0, 64'd25);
    // The second push overwrites the selected slot, which then shows the new frame.
    plan_req(CMD_PUSH, 64'd40, 32'hA3, 64'd40);
    plan_req(CMD_PUSH, 64'd50, 32'hA4, 64'd40);
    plan_req(CMD_QUERY, '0, '0, 64'd50);
    plan_req(CMD_QUERY, '0, '0, 64'd51);
  endtask

  // ---------------------------------------------------------------------------
  // Random phase: new capacity, then a mix that mostly pushes ordered times and
  // seeks near stored ones, with out-of-order and extreme values as noise.
  // ---------------------------------------------------------------------------
  task automatic run_phase(input logic [CAP_W-1:0] cap_raw, input int count,
                           input int push_pct);
    ring_req_t         r;
    logic [TIME_W-1:0] ts_now;
    int                pick;
    int                s;

    wait_idle();
    write_capacity(cap_raw);
    ts_now = {$urandom, $urandom} >> $urandom_range(0, 63);
    for (int k = 0; k < count; k++) begin
      if (k == count / 3) begin
        // Ask the result side to hold off for a long stretch while requests keep coming.
        park_asked++;
      end
      r.frame_handle = $urandom;
      r.frame_time   = {$urandom, $urandom};
      pick = $urandom_range(0, 99);
      if (pick < push_pct) begin
        r.command = CMD_PUSH;
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
          ts_now = ts_now + 64'($urandom_range(0, 40));
        end else if (pick < 85) begin
          ts_now = {$urandom, $urandom};
        end else if (pick < 96) begin
          ts_now = ts_now;
        end else if (pick < 98) begin
          ts_now = TIME_MAX;
        end else begin
          ts_now = '0;
        end
        r.frame_time = ts_now;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
          r.command = CMD_SEEK;
        end else if (pick < 60) begin
          r.command = CMD_PREV;
        end else if (pick < 85) begin
          r.command = CMD_NEXT;
        end else if (pick < 95) begin
          r.command = CMD_QUERY;
        end else begin
          case ($urandom_range(0, 2))
            0:       r.command = CMD_SPARE_5;
            1:       r.command = CMD_SPARE_6;
            default: r.command = CMD_SPARE_7;
          endcase
        end
      end
      // Search positions cluster around stored times so that ties and exact hits occur.
      pick = $urandom_range(0, 99);
      if (ring_fill != 0 && pick < 45) begin
        s = $urandom_range(0, ring_fill - 1);
        r.search_time = slot_time[s] + 64'($urandom_range(0, 6)) - 64'd3;
      end else if (pick < 55) begin
        r.search_time = '0;
      end else if (pick < 65) begin
        r.search_time = TIME_MAX;
      end else if (pick < 85) begin
        r.search_time = ts_now - 64'($urandom_range(0, 200));
      end else begin
        r.search_time = {$urandom, $urandom};
      end
      send_request(r, 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: ready follows segments of full speed, light and heavy stalls,
  // plus a long hold-off whenever the stimulus asks for one.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int seg;
    int mode;
    int hold;
    int park_done;

    hold      = 0;
    park_done = 0;
    rsp_bus.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 2);
      seg  = $urandom_range(10, 150);
      repeat (seg) begin
        @(negedge clk_i);
        if (park_done != park_asked) begin
          park_done = park_asked;
          hold      = PARK_CYCLES;
        end
        if (hold > 0) begin
          hold--;
          rsp_bus.ready <= 1'b0;
        end else begin
          case (mode)
            0:       rsp_bus.ready <= 1'b1;
            1:       rsp_bus.ready <= 1'($urandom_range(0, 1));
            default: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
          endcase
        end
      end
    end
  end

  task automatic check_field(input string what, input logic [TIME_W-1:0] want,
                             input logic [TIME_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  // Every accepted result is matched against the oldest outstanding prediction.
  always @(posedge clk_i) begin : result_check
    ring_rsp_t want;
    if (rst_ni === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
      if (ring_expect.size() == 0) begin
        $display("%0t: result with no request outstanding, actual slot %0h status %0h",
                 $time, rsp_bus.slot, rsp_bus.status);
        mismatches++;
      end else begin
        want = ring_expect.pop_front();
        check_field("status",       want.status,       rsp_bus.status);
        check_field("found_handle", want.found_handle, rsp_bus.found_handle);
        check_field("found_time",   want.found_time,   rsp_bus.found_time);
        check_field("slot",         want.slot,         rsp_bus.slot);
        check_field("has_previous", want.has_previous, rsp_bus.has_previous);
        check_field("has_next",     want.has_next,     rsp_bus.has_next);
        check_field("in_range",     want.in_range,     rsp_bus.in_range);
        check_field("oldest_time",  want.oldest_time,  rsp_bus.oldest_time);
        check_field("newest_time",  want.newest_time,  rsp_bus.newest_time);
        check_field("fill_count",   want.fill_count,   rsp_bus.fill_count);
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  int cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus sequence: reset, directed plan, then random phases that visit the
  // clamp extremes, the smallest and the largest ring and sizes in between.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    rst_ni               = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    cmd_bus.valid        = 1'b0;
    cmd_bus.command      = CMD_QUERY;
    cmd_bus.frame_time   = '0;
    cmd_bus.frame_handle = '0;
    cmd_bus.search_time  = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    build_plan();
    foreach (plan[k]) begin
      if (plan[k].is_cfg) begin
        wait_idle();
        write_capacity(plan[k].cap_raw);
      end else begin
        send_request(plan[k].req, plan[k].typed, plan[k].want);
      end
    end

    run_phase(11'd3, 150, 40);
    run_phase(11'd1, 120, 50);
    run_phase(11'd2047, 180, 45);
    run_phase(11'd2, 100, 40);
    run_phase(CAP_W'($urandom_range(4, 64)), 180, 35);
    run_phase(11'd1024, 150, 60);
    run_phase(CAP_W'($urandom_range(2, 600)), 200, 70);
    run_phase(11'd0, 80, 40);
    run_phase(11'd16, 190, 30);

    // Drain everything still in flight, then report.
    wait_idle();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
